// ===== src/ckmc_pkg.sv =====
// Shared types and constants of the color key mask centroid unit.
package ckmc_pkg;

    localparam int CHAN_W      = 8;
    localparam int WIDTH_REG_W = 13;
    localparam int COORD_W     = 12;
    localparam int TOTAL_W     = 25;
    localparam int REG_INDEX_W = 3;
    localparam int REG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAN_W-1:0]      KEY_RED_RESET   = 8'd208;
    localparam logic [CHAN_W-1:0]      KEY_GREEN_RESET = 8'd138;
    localparam logic [CHAN_W-1:0]      KEY_BLUE_RESET  = 8'd116;
    localparam logic [CHAN_W-1:0]      TOLERANCE_RESET = 8'd25;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET     = 13'd640;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_TOLERANCE = 3'd3,
        REG_WIDTH     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic               is_match;
        logic               frame_done;
        logic               centroid_valid;
        logic [COORD_W-1:0] centroid_col;
        logic [COORD_W-1:0] centroid_row;
        logic [TOTAL_W-1:0] match_total;
    } result_t;

endpackage

// ===== src/ckmc_front.sv =====
// Front end: configuration registers, key match, position tracking and accumulation.
module ckmc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [ckmc_pkg::REG_INDEX_W-1:0]       wr_index,
    input  logic [ckmc_pkg::REG_DATA_W-1:0]        wr_data,
    input  logic                                   accept,
    input  ckmc_pkg::pixel_t                       pixel,
    output logic [1 + 1 + $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1)
                  + 2 * ($clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1)
                  + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT))
                     ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))) - 1 : 0] entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam longint unsigned HIT_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int HW = $clog2(HIT_CAP + 1);
    localparam int SW = HW + ((CW > RW) ? CW : RW);
    localparam int PW = ((CW + 1) > ckmc_pkg::WIDTH_REG_W) ? (CW + 1) : ckmc_pkg::WIDTH_REG_W;

    typedef struct packed {
        logic          is_match;
        logic          last;
        logic [HW-1:0] hit;
        logic [SW-1:0] col_sum;
        logic [SW-1:0] row_sum;
    } entry_t;

    logic [ckmc_pkg::CHAN_W-1:0]      key_red_reg;
    logic [ckmc_pkg::CHAN_W-1:0]      key_green_reg;
    logic [ckmc_pkg::CHAN_W-1:0]      key_blue_reg;
    logic [ckmc_pkg::CHAN_W-1:0]      tol_reg;
    logic [ckmc_pkg::WIDTH_REG_W-1:0] width_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [HW-1:0] hit_reg, hit_next;
    logic [SW-1:0] csum_reg, csum_next;
    logic [SW-1:0] rsum_reg, rsum_next;

    logic          match;
    logic          take;
    logic [HW-1:0] hit_acc;
    logic [SW-1:0] csum_acc;
    logic [SW-1:0] rsum_acc;
    logic [PW-1:0] width_ext;
    logic [PW-1:0] eff_width;
    logic [PW-1:0] col_inc;
    entry_t        entry_w;

    function automatic logic near_key(
        input logic [ckmc_pkg::CHAN_W-1:0] px,
        input logic [ckmc_pkg::CHAN_W-1:0] key,
        input logic [ckmc_pkg::CHAN_W-1:0] tol
    );
        logic [ckmc_pkg::CHAN_W-1:0] diff;
        diff = (px >= key) ? (px - key) : (key - px);
        return diff <= tol;
    endfunction

    always_comb
    begin
        match = near_key(pixel.red, key_red_reg, tol_reg)
              && near_key(pixel.green, key_green_reg, tol_reg)
              && near_key(pixel.blue, key_blue_reg, tol_reg);
        // Stop counting once the count is pinned at the cap.
        take     = match && (hit_reg < HW'(HIT_CAP));
        hit_acc  = hit_reg + HW'(take);
        csum_acc = csum_reg + (take ? SW'(col_reg) : SW'(0));
        rsum_acc = rsum_reg + (take ? SW'(row_reg) : SW'(0));

        width_ext = PW'(width_reg);
        if (width_ext == PW'(0))
        begin
            eff_width = PW'(1);
        end
        else if (width_ext > PW'(MAX_WIDTH))
        begin
            eff_width = PW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        col_inc = PW'(col_reg) + PW'(1);

        if (pixel.last_pixel)
        begin
            col_next  = '0;
            row_next  = '0;
            hit_next  = '0;
            csum_next = '0;
            rsum_next = '0;
        end
        else
        begin
            hit_next  = hit_acc;
            csum_next = csum_acc;
            rsum_next = rsum_acc;
            if (col_inc >= eff_width)
            begin
                col_next = '0;
                row_next = (row_reg < RW'(MAX_HEIGHT - 1)) ? (row_reg + RW'(1)) : row_reg;
            end
            else
            begin
                col_next = col_inc[CW-1:0];
                row_next = row_reg;
            end
        end

        entry_w.is_match = match;
        entry_w.last     = pixel.last_pixel;
        entry_w.hit      = hit_acc;
        entry_w.col_sum  = csum_acc;
        entry_w.row_sum  = rsum_acc;
    end

    assign entry = entry_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_red_reg   <= ckmc_pkg::KEY_RED_RESET;
            key_green_reg <= ckmc_pkg::KEY_GREEN_RESET;
            key_blue_reg  <= ckmc_pkg::KEY_BLUE_RESET;
            tol_reg       <= ckmc_pkg::TOLERANCE_RESET;
            width_reg     <= ckmc_pkg::WIDTH_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            hit_reg       <= '0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (ckmc_pkg::reg_index_t'(wr_index))
                    ckmc_pkg::REG_KEY_RED:   key_red_reg   <= wr_data[ckmc_pkg::CHAN_W-1:0];
                    ckmc_pkg::REG_KEY_GREEN: key_green_reg <= wr_data[ckmc_pkg::CHAN_W-1:0];
                    ckmc_pkg::REG_KEY_BLUE:  key_blue_reg  <= wr_data[ckmc_pkg::CHAN_W-1:0];
                    ckmc_pkg::REG_TOLERANCE: tol_reg       <= wr_data[ckmc_pkg::CHAN_W-1:0];
                    ckmc_pkg::REG_WIDTH:     width_reg     <= wr_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                hit_reg  <= hit_next;
                csum_reg <= csum_next;
                rsum_reg <= rsum_next;
            end
        end
    end

endmodule

// ===== src/ckmc_fifo.sv =====
// Small register queue between the front end and the back end.
module ckmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [NW-1:0]    count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == NW'(0));
    assign rdata = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? AW'(0) : (wptr_reg + AW'(1));
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? AW'(0) : (rptr_reg + AW'(1));
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

// ===== src/ckmc_div.sv =====
// Restoring divider: one quotient bit per cycle.
module ckmc_div #(
    parameter int DW = 37,
    parameter int VW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int KW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;

    logic [VW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign done     = !busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit, subtract when the divisor fits.
            rem_reg <= fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= KW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/ckmc_back.sv =====
// Back end: drains the queue, runs the centroid division and holds the result word.
module ckmc_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1 + 1 + $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1)
                  + 2 * ($clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 1)
                  + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT))
                     ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))) - 1 : 0] head,
    input  logic                head_valid,
    output logic                head_pop,
    input  logic                pop,
    output logic                empty,
    output ckmc_pkg::result_t   result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam longint unsigned HIT_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int HW = $clog2(HIT_CAP + 1);
    localparam int SW = HW + ((CW > RW) ? CW : RW);

    typedef struct packed {
        logic          is_match;
        logic          last;
        logic [HW-1:0] hit;
        logic [SW-1:0] col_sum;
        logic [SW-1:0] row_sum;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t             state_reg;
    ckmc_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic [HW-1:0]      total_reg;

    entry_t             head_e;
    logic               out_free;
    logic               take_head;
    logic               head_div;
    logic               finish;
    logic               col_done;
    logic               row_done;
    logic [SW-1:0]      col_quo;
    logic [SW-1:0]      row_quo;
    ckmc_pkg::result_t  direct;
    ckmc_pkg::result_t  divided;

    assign head_e    = head;
    assign out_free  = !out_valid_reg || pop;
    assign take_head = (state_reg == ST_IDLE) && head_valid && out_free;
    assign head_div  = take_head && head_e.last && (head_e.hit != HW'(0));
    assign finish    = (state_reg == ST_DIVIDE) && col_done && row_done && out_free;
    assign head_pop  = take_head;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    ckmc_div #(.DW(SW), .VW(HW)) u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (head_div),
        .dividend (head_e.col_sum),
        .divisor  (head_e.hit),
        .done     (col_done),
        .quotient (col_quo)
    );

    ckmc_div #(.DW(SW), .VW(HW)) u_div_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (head_div),
        .dividend (head_e.row_sum),
        .divisor  (head_e.hit),
        .done     (row_done),
        .quotient (row_quo)
    );

    always_comb
    begin
        direct.is_match       = head_e.is_match;
        direct.frame_done     = head_e.last;
        direct.centroid_valid = 1'b0;
        direct.centroid_col   = '0;
        direct.centroid_row   = '0;
        direct.match_total    = head_e.last ? ckmc_pkg::TOTAL_W'(head_e.hit) : '0;

        divided.is_match       = out_reg.is_match;
        divided.frame_done     = 1'b1;
        divided.centroid_valid = 1'b1;
        divided.centroid_col   = ckmc_pkg::COORD_W'(col_quo);
        divided.centroid_row   = ckmc_pkg::COORD_W'(row_quo);
        divided.match_total    = ckmc_pkg::TOTAL_W'(total_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            total_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_div)
                    begin
                        // Park the match bit and count while the dividers run.
                        state_reg        <= ST_DIVIDE;
                        total_reg        <= head_e.hit;
                        out_reg.is_match <= head_e.is_match;
                        out_valid_reg    <= 1'b0;
                    end
                    else if (take_head)
                    begin
                        out_reg       <= direct;
                        out_valid_reg <= 1'b1;
                    end
                    else if (pop)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_DIVIDE:
                begin
                    if (finish)
                    begin
                        out_reg       <= divided;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (pop)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/color_key_mask_centroid_unit.sv =====
// A pixel word passes through the queue and then the result register on its way to the ports,
// when nothing stalls. Throughput: one word per cycle for ordinary pixels while results are
// popped; the last pixel of a frame with matches holds the back end while the bit-serial
// dividers work through all SW sum bits (SW = sum width, 37 at default sizes); the front keeps
// taking words into the queue meanwhile, until it fills.
// Reset: rst_n clears position, counters, queue and result, and loads the key colour,
// tolerance and frame width with their defaults.
module color_key_mask_centroid_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              wr_en,
    input  logic [ckmc_pkg::REG_INDEX_W-1:0]  wr_index,
    input  logic [ckmc_pkg::REG_DATA_W-1:0]   wr_data,
    // pixel words in
    input  logic                              push,
    output logic                              full,
    input  ckmc_pkg::pixel_t                  pixel,
    // result words out
    output logic                              empty,
    input  logic                              pop,
    output ckmc_pkg::result_t                 result
);

    // Queue word: match bit, last flag, hit count and both coordinate sums.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam longint unsigned HIT_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int HW = $clog2(HIT_CAP + 1);
    localparam int SW = HW + ((CW > RW) ? CW : RW);
    localparam int EW = 2 + HW + 2 * SW;

    logic          accept;
    logic [EW-1:0] front_entry;
    logic [EW-1:0] head_entry;
    logic          q_empty;
    logic          q_pop;

    // Take a pixel only when the queue has room.
    assign accept = push && !full;

    // Front: classify the pixel, advance column and row, accumulate matches.
    ckmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .pixel    (pixel),
        .entry    (front_entry)
    );

    // Queue lets the front keep streaming while the back end divides.
    ckmc_fifo #(
        .WIDTH (EW),
        .DEPTH (ckmc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (front_entry),
        .rd    (q_pop),
        .rdata (head_entry),
        .full  (full),
        .empty (q_empty)
    );

    // Back: pass ordinary words through, divide the sums on a frame end with matches, hold the result word.
    ckmc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .head_valid (!q_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

// ===== tb/color_key_mask_centroid_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the color key mask centroid unit.
module color_key_mask_centroid_unit_test;

    // Sizes the block is built with; the predictor uses the same bounds.
    localparam int FRAME_MAX_W = 4096;
    localparam int FRAME_MAX_H = 4096;
    localparam longint unsigned HIT_CAP = longint'(FRAME_MAX_W) * FRAME_MAX_H;

    // The last pixel of a frame with matches holds the back end while the dividers run.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 1325;
    localparam int SWEEP_ITEMS  = 200;
    localparam int MAX_REPORTS  = 10;

    // Flavors of random pixel content.
    typedef enum int {
        PX_MATCH,
        PX_NEAR_MISS,
        PX_NOISE
    } pixel_kind_t;

    // Keeps its own copy of the registers and the frame counters, predicts
    // one result word per accepted pixel word and checks what comes out.
    class centroid_scoreboard;
        logic [ckmc_pkg::CHAN_W-1:0]      key_red;
        logic [ckmc_pkg::CHAN_W-1:0]      key_green;
        logic [ckmc_pkg::CHAN_W-1:0]      key_blue;
        logic [ckmc_pkg::CHAN_W-1:0]      tolerance;
        logic [ckmc_pkg::WIDTH_REG_W-1:0] frame_width;
        int unsigned                      col_pos;
        int unsigned                      row_pos;
        longint unsigned                  hits;
        longint unsigned                  col_sum;
        longint unsigned                  row_sum;
        ckmc_pkg::result_t                expected_q[$];
        int                               errors;

        function new();
            errors      = 0;
            key_red     = ckmc_pkg::KEY_RED_RESET;
            key_green   = ckmc_pkg::KEY_GREEN_RESET;
            key_blue    = ckmc_pkg::KEY_BLUE_RESET;
            tolerance   = ckmc_pkg::TOLERANCE_RESET;
            frame_width = ckmc_pkg::WIDTH_RESET;
            col_pos     = 0;
            row_pos     = 0;
            hits        = 0;
            col_sum     = 0;
            row_sum     = 0;
        endfunction

        function void write_reg(ckmc_pkg::reg_index_t idx,
                                logic [ckmc_pkg::REG_DATA_W-1:0] data);
            case (idx)
                ckmc_pkg::REG_KEY_RED:   key_red     = data[ckmc_pkg::CHAN_W-1:0];
                ckmc_pkg::REG_KEY_GREEN: key_green   = data[ckmc_pkg::CHAN_W-1:0];
                ckmc_pkg::REG_KEY_BLUE:  key_blue    = data[ckmc_pkg::CHAN_W-1:0];
                ckmc_pkg::REG_TOLERANCE: tolerance   = data[ckmc_pkg::CHAN_W-1:0];
                ckmc_pkg::REG_WIDTH:     frame_width = data[ckmc_pkg::WIDTH_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function bit channel_close(logic [ckmc_pkg::CHAN_W-1:0] chan,
                                   logic [ckmc_pkg::CHAN_W-1:0] key);
            logic [ckmc_pkg::CHAN_W-1:0] diff;
            diff = (chan >= key) ? chan - key : key - chan;
            return diff <= tolerance;
        endfunction

        function void note_pixel(ckmc_pkg::pixel_t p);
            ckmc_pkg::result_t want;
            bit                hit;
            int unsigned       w;
            hit = channel_close(p.red, key_red) && channel_close(p.green, key_green) &&
                  channel_close(p.blue, key_blue);
            want = '0;
            want.is_match   = hit;
            want.frame_done = p.last_pixel;
            // Once the count is saturated, further matches leave the sums alone.
            if (hit && hits < HIT_CAP)
            begin
                hits    = hits + 1;
                col_sum = col_sum + col_pos;
                row_sum = row_sum + row_pos;
            end
            if (p.last_pixel)
            begin
                want.match_total = ckmc_pkg::TOTAL_W'(hits);
                if (hits != 0)
                begin
                    want.centroid_valid = 1'b1;
                    want.centroid_col   = ckmc_pkg::COORD_W'(col_sum / hits);
                    want.centroid_row   = ckmc_pkg::COORD_W'(row_sum / hits);
                end
                col_pos = 0;
                row_pos = 0;
                hits    = 0;
                col_sum = 0;
                row_sum = 0;
            end
            else
            begin
                // Width zero acts as one, anything past the maximum as the maximum.
                w = frame_width;
                if (w == 0)
                    w = 1;
                if (w > FRAME_MAX_W)
                    w = FRAME_MAX_W;
                if (col_pos + 1 >= w)
                begin
                    col_pos = 0;
                    if (row_pos < FRAME_MAX_H - 1)
                        row_pos = row_pos + 1;
                end
                else
                    col_pos = col_pos + 1;
            end
            expected_q.push_back(want);
        endfunction

        function void report(string what, ckmc_pkg::result_t want, ckmc_pkg::result_t got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t %s: expected match=%0b done=%0b valid=%0b col=%0d row=%0d total=%0d",
                         $time, what, want.is_match, want.frame_done, want.centroid_valid,
                         want.centroid_col, want.centroid_row, want.match_total,
                         "\n    got match=%0b done=%0b valid=%0b col=%0d row=%0d total=%0d",
                         got.is_match, got.frame_done, got.centroid_valid,
                         got.centroid_col, got.centroid_row, got.match_total);
        endfunction

        function void check_result(ckmc_pkg::result_t got);
            ckmc_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report("result word with nothing expected", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.is_match !== want.is_match || got.frame_done !== want.frame_done ||
                got.centroid_valid !== want.centroid_valid ||
                got.centroid_col !== want.centroid_col ||
                got.centroid_row !== want.centroid_row ||
                got.match_total !== want.match_total)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             wr_en;
    logic [ckmc_pkg::REG_INDEX_W-1:0] wr_index;
    logic [ckmc_pkg::REG_DATA_W-1:0]  wr_data;
    logic                             push;
    logic                             full;
    ckmc_pkg::pixel_t                 pixel;
    logic                             empty;
    logic                             pop;
    ckmc_pkg::result_t                result;

    centroid_scoreboard sb = new();

    // quiet turns all idling off; idle_pct is the chance of an idle burst per word.
    bit quiet       = 1'b0;
    int idle_pct    = 0;
    // Long receiver hold-off, counted down by the result side.
    int hold_off    = 0;
    int cycle_count = 0;

    color_key_mask_centroid_unit #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .pixel    (pixel),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("color_key_mask_centroid_unit_test failed");
            $finish;
        end
    end

    // Result side: decide pop at the falling edge, in bursts of stalls.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                pop      <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(99, 0) < idle_pct)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(9, 0);
            end
            else
                pop <= 1'b1;
        end
    end

    // Check every word taken off the result side against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    // Offer one pixel word; hold it until the block takes it. Enter and leave at a
    // falling edge; push stays high on return so back-to-back words need no gap.
    task automatic send_pixel(ckmc_pkg::pixel_t p);
        int gap;
        if (!quiet && $urandom_range(99, 0) < idle_pct)
        begin
            push <= 1'b0;
            gap = $urandom_range(10, 1);
            repeat (gap) @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    // Drop push and wait until every predicted word has come back, then let the
    // divider settle.
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write one register; wr_en stays high for the caller to drop.
    task automatic write_reg(ckmc_pkg::reg_index_t idx, int unsigned value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[ckmc_pkg::REG_DATA_W-1:0];
        @(posedge clk);
        sb.write_reg(idx, value[ckmc_pkg::REG_DATA_W-1:0]);
        @(negedge clk);
    endtask

    // Reprogram every register once the block has gone idle.
    task automatic configure(int unsigned kr, int unsigned kg, int unsigned kb,
                             int unsigned tol, int unsigned width);
        wait_idle();
        write_reg(ckmc_pkg::REG_KEY_RED, kr);
        write_reg(ckmc_pkg::REG_KEY_GREEN, kg);
        write_reg(ckmc_pkg::REG_KEY_BLUE, kb);
        write_reg(ckmc_pkg::REG_TOLERANCE, tol);
        write_reg(ckmc_pkg::REG_WIDTH, width);
        wr_en <= 1'b0;
    endtask

    function automatic ckmc_pkg::pixel_t rgb(int r, int g, int b, bit last);
        ckmc_pkg::pixel_t p;
        p.red        = r[ckmc_pkg::CHAN_W-1:0];
        p.green      = g[ckmc_pkg::CHAN_W-1:0];
        p.blue       = b[ckmc_pkg::CHAN_W-1:0];
        p.last_pixel = last;
        return p;
    endfunction

    // A channel value within tolerance of the key, often right on the edge.
    function automatic int close_to(int key, int tol);
        int lo;
        int hi;
        lo = (key - tol < 0) ? 0 : key - tol;
        hi = (key + tol > 255) ? 255 : key + tol;
        case ($urandom_range(3, 0))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // A channel value one step past the tolerance, where one exists.
    function automatic int just_outside(int key, int tol);
        bit up_ok;
        bit down_ok;
        up_ok   = key + tol + 1 <= 255;
        down_ok = key - tol - 1 >= 0;
        if (up_ok && (!down_ok || $urandom_range(1, 0) == 1))
            return key + tol + 1;
        if (down_ok)
            return key - tol - 1;
        return $urandom_range(255, 0);
    endfunction

    // Build a pixel around the key colour now in force.
    function automatic ckmc_pkg::pixel_t make_pixel(pixel_kind_t kind, bit last);
        int keys[3];
        int vals[3];
        int tol;
        int odd;
        keys[0] = sb.key_red;
        keys[1] = sb.key_green;
        keys[2] = sb.key_blue;
        tol     = sb.tolerance;
        odd     = $urandom_range(2, 0);
        for (int c = 0; c < 3; c++)
        begin
            case (kind)
                PX_MATCH:     vals[c] = close_to(keys[c], tol);
                PX_NEAR_MISS: vals[c] = (c == odd) ? just_outside(keys[c], tol)
                                                   : close_to(keys[c], tol);
                default:      vals[c] = $urandom_range(255, 0);
            endcase
        end
        return rgb(vals[0], vals[1], vals[2], last);
    endfunction

    // Random frames of mostly short length; a phase may stop mid-frame, so the
    // next setting takes over part way through a row.
    task automatic run_phase(int items, bit squeeze);
        int          frame_left;
        int          r;
        pixel_kind_t kind;
        frame_left = 0;
        for (int i = 0; i < items; i++)
        begin
            if (frame_left == 0)
                frame_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 41)
                                                         : $urandom_range(40, 1);
            r    = $urandom_range(99, 0);
            kind = (r < 50) ? PX_MATCH : ((r < 70) ? PX_NEAR_MISS : PX_NOISE);
            send_pixel(make_pixel(kind, frame_left == 1));
            frame_left--;
            // Hold the result side off long enough for the queue to fill and
            // push back on the sender.
            if (squeeze && i == 8)
                hold_off <= 200;
        end
    endtask

    initial
    begin : stimulus
        int          remaining;
        int          count;
        int          phase;
        int          r;
        int unsigned keys[3];
        int unsigned tol;
        int unsigned width;

        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        push     = 1'b0;
        pixel    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: key (208,138,116), tolerance 25, width 640.
        // Exact key, both tolerance edges, one step past them, the extremes.
        send_pixel(rgb(208, 138, 116, 1'b0));
        send_pixel(rgb(233, 163, 141, 1'b0));
        send_pixel(rgb(183, 113, 91, 1'b0));
        send_pixel(rgb(234, 138, 116, 1'b0));
        send_pixel(rgb(208, 138, 90, 1'b0));
        send_pixel(rgb(0, 0, 0, 1'b0));
        send_pixel(rgb(255, 255, 255, 1'b1));
        // Frame without a single match.
        send_pixel(rgb(10, 20, 30, 1'b0));
        send_pixel(rgb(0, 255, 0, 1'b1));
        // One-pixel frame that matches.
        send_pixel(rgb(208, 138, 116, 1'b1));

        // Width zero acts as one: every pixel starts a new row. Widest tolerance.
        configure(0, 255, 0, 255, 0);
        send_pixel(rgb(0, 0, 0, 1'b0));
        send_pixel(rgb(255, 255, 255, 1'b0));
        send_pixel(rgb(0, 255, 0, 1'b0));
        send_pixel(rgb(255, 0, 255, 1'b1));

        // Zero tolerance, width far above the maximum.
        configure(255, 0, 128, 0, 8191);
        send_pixel(rgb(255, 0, 128, 1'b0));
        send_pixel(rgb(254, 0, 128, 1'b0));
        send_pixel(rgb(255, 1, 128, 1'b0));
        send_pixel(rgb(255, 0, 128, 1'b0));
        send_pixel(rgb(255, 0, 129, 1'b1));

        // Narrow the row while the column already sits past the new width.
        configure(100, 100, 100, 255, 4);
        send_pixel(rgb(1, 2, 3, 1'b0));
        send_pixel(rgb(4, 5, 6, 1'b0));
        send_pixel(rgb(7, 8, 9, 1'b0));
        configure(100, 100, 100, 255, 2);
        send_pixel(rgb(10, 11, 12, 1'b0));
        send_pixel(rgb(13, 14, 15, 1'b0));
        send_pixel(rgb(16, 17, 18, 1'b1));

        // One tall frame of single-pixel rows, every pixel a match, to walk the
        // row position far down the frame.
        configure($urandom_range(255, 0), $urandom_range(255, 0),
                  $urandom_range(255, 0), 255, 1);
        idle_pct = 2;
        for (int i = 0; i < SWEEP_ITEMS; i++)
            send_pixel(make_pixel(PX_NOISE, i == SWEEP_ITEMS - 1));

        // Random phases, each under its own register setting. The final phase
        // runs with no idling on either side.
        remaining = RANDOM_ITEMS;
        phase     = 0;
        while (remaining > 0)
        begin
            count = $urandom_range(160, 60);
            if (remaining - count < 150)
            begin
                count = remaining;
                quiet = 1'b1;
            end
            for (int c = 0; c < 3; c++)
            begin
                r = $urandom_range(5, 0);
                keys[c] = (r == 0) ? 0 : ((r == 1) ? 255 : $urandom_range(255, 0));
            end
            case ($urandom_range(5, 0))
                0:       tol = 0;
                1:       tol = 255;
                2:       tol = $urandom_range(255, 0);
                default: tol = $urandom_range(40, 0);
            endcase
            case ($urandom_range(11, 0))
                0:       width = 0;
                1:       width = 1;
                2:       width = FRAME_MAX_W;
                3:       width = FRAME_MAX_W + 1;
                4:       width = 8191;
                5:       width = $urandom_range(8191, 1);
                default: width = $urandom_range(16, 1);
            endcase
            configure(keys[0], keys[1], keys[2], tol, width);
            case ($urandom_range(2, 0))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            run_phase(count, phase == 1);
            remaining -= count;
            phase++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("color_key_mask_centroid_unit_test passed");
        else
            $display("color_key_mask_centroid_unit_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ckmc_pkg.sv
src/ckmc_front.sv
src/ckmc_fifo.sv
src/ckmc_div.sv
src/ckmc_back.sv
src/color_key_mask_centroid_unit.sv
tb/color_key_mask_centroid_unit_test.sv
